// ===== hw/rtl/tpc_pkg.sv =====
// Package for the triangle plane clipper.
// Holds default widths and the configuration register indexes; no dependencies.
package tpc_pkg;

	localparam int COORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int THR_BITS       = 16;
	localparam int CFG_INDEX_BITS = 3;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_PLANE_POINT_X  = 3'd0,
		REG_PLANE_POINT_Y  = 3'd1,
		REG_PLANE_POINT_Z  = 3'd2,
		REG_PLANE_NORMAL_X = 3'd3,
		REG_PLANE_NORMAL_Y = 3'd4,
		REG_PLANE_NORMAL_Z = 3'd5,
		REG_SIDE_THRESHOLD = 3'd6
	} cfg_reg_t;

endpackage

// ===== hw/rtl/triangle_plane_clipper.sv =====
// Triangle plane clipper. The pipeline takes one triangle per cycle when the output side does
// not stall it; the output side sends one word per cycle while tri_ready is high, so a triangle
// that splits into n words holds the input until its last word is taken.
// The cut divider resolves two quotient bits per stage. Reset clears all valid bits and sets
// the plane to the origin with normal +z and a zero threshold.
// Depends on tpc_pkg.
module triangle_plane_clipper #(
	parameter int COORD_BITS = tpc_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = tpc_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tpc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [COORD_BITS-1:0]               cfg_data,
	input  logic                                vertex_valid,
	output logic                                vertex_ready,
	input  logic signed [COORD_BITS-1:0]        vertex0_x,
	input  logic signed [COORD_BITS-1:0]        vertex0_y,
	input  logic signed [COORD_BITS-1:0]        vertex0_z,
	input  logic signed [COORD_BITS-1:0]        vertex1_x,
	input  logic signed [COORD_BITS-1:0]        vertex1_y,
	input  logic signed [COORD_BITS-1:0]        vertex1_z,
	input  logic signed [COORD_BITS-1:0]        vertex2_x,
	input  logic signed [COORD_BITS-1:0]        vertex2_y,
	input  logic signed [COORD_BITS-1:0]        vertex2_z,
	output logic                                tri_valid,
	input  logic                                tri_ready,
	output logic                                side,
	output logic signed [COORD_BITS-1:0]        out0_x,
	output logic signed [COORD_BITS-1:0]        out0_y,
	output logic signed [COORD_BITS-1:0]        out0_z,
	output logic signed [COORD_BITS-1:0]        out1_x,
	output logic signed [COORD_BITS-1:0]        out1_y,
	output logic signed [COORD_BITS-1:0]        out1_z,
	output logic signed [COORD_BITS-1:0]        out2_x,
	output logic signed [COORD_BITS-1:0]        out2_y,
	output logic signed [COORD_BITS-1:0]        out2_z,
	output logic                                last_of_run
);
	import tpc_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int FB = FRAC_BITS;
	localparam int DS = (FB + 1) / 2;
	localparam int MW = (2 * CB + 1 > CB + FB + 2) ? 2 * CB + 1 : CB + FB + 2;
	localparam logic signed [MW-1:0] MAXW = {{(MW-CB+1){1'b0}}, {(CB-1){1'b1}}};
	localparam logic signed [MW-1:0] MINW = {{(MW-CB+1){1'b1}}, {(CB-1){1'b0}}};
	localparam logic signed [MW-1:0] BIAS = {{(MW-FB){1'b0}}, {FB{1'b1}}};
	localparam logic signed [CB+1:0] SMAX = {3'b000, {(CB-1){1'b1}}};
	localparam logic signed [CB+1:0] SMIN = {3'b111, {(CB-1){1'b0}}};

	function automatic logic signed [CB-1:0] rnd_sat(input logic signed [MW-1:0] p);
		logic signed [MW-1:0] q;
		q = p[MW-1] ? ((p + BIAS) >>> FB) : (p >>> FB);
		if (q > MAXW) return MAXW[CB-1:0];
		else if (q < MINW) return MINW[CB-1:0];
		else return q[CB-1:0];
	endfunction

	function automatic logic signed [CB-1:0] sat_sum(input logic signed [CB+1:0] s);
		if (s > SMAX) return SMAX[CB-1:0];
		else if (s < SMIN) return SMIN[CB-1:0];
		else return s[CB-1:0];
	endfunction

	function automatic logic [CB-1:0] abs_c(input logic signed [CB-1:0] d);
		return d[CB-1] ? (~d + 1'b1) : d;
	endfunction

	// Configuration registers.
	logic signed [CB-1:0] pp_q [3];
	logic signed [CB-1:0] pn_q [3];
	logic [THR_BITS-1:0]  thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pp_q[0] <= '0;
			pp_q[1] <= '0;
			pp_q[2] <= '0;
			pn_q[0] <= '0;
			pn_q[1] <= '0;
			pn_q[2] <= CB'(1) << FB;
			thr_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PLANE_POINT_X:  pp_q[0] <= cfg_data;
				REG_PLANE_POINT_Y:  pp_q[1] <= cfg_data;
				REG_PLANE_POINT_Z:  pp_q[2] <= cfg_data;
				REG_PLANE_NORMAL_X: pn_q[0] <= cfg_data;
				REG_PLANE_NORMAL_Y: pn_q[1] <= cfg_data;
				REG_PLANE_NORMAL_Z: pn_q[2] <= cfg_data;
				REG_SIDE_THRESHOLD: thr_q   <= cfg_data[THR_BITS-1:0];
				default: ;
			endcase
		end
	end

	logic adv;
	logic signed [CB-1:0] vin [3][3];

	assign vin[0][0] = vertex0_x;
	assign vin[0][1] = vertex0_y;
	assign vin[0][2] = vertex0_z;
	assign vin[1][0] = vertex1_x;
	assign vin[1][1] = vertex1_y;
	assign vin[1][2] = vertex1_z;
	assign vin[2][0] = vertex2_x;
	assign vin[2][1] = vertex2_y;
	assign vin[2][2] = vertex2_z;

	// Stage registers.
	logic vld_s1, vld_s2, vld_s3, vld_s5, vld_s6;
	logic vld_dv_s [DS+1];
	logic signed [CB-1:0]      v_s1 [3][3];
	logic signed [CB:0]        diff_s1 [3][3];
	logic signed [CB-1:0]      v_s2 [3][3];
	logic signed [2*CB:0]      prod_s2 [3][3];
	logic signed [CB-1:0]      v_s3 [3][3];
	logic signed [CB-1:0]      d_s3 [3];
	logic signed [CB-1:0]      v_dv_s [DS+1][3][3];
	logic [2:0]                pos_dv_s [DS+1];
	logic [2:0]                neg_dv_s [DS+1];
	logic [CB+1:0]             rem_dv_s [DS+1][3];
	logic [CB:0]               den_dv_s [DS+1][3];
	logic [FB-1:0]             t_dv_s [DS+1][3];
	logic signed [CB:0]        dba_dv_s [DS+1][3][3];
	logic signed [CB-1:0]      v_s5 [3][3];
	logic [2:0]                pos_s5, neg_s5;
	logic signed [CB+FB+1:0]   prod_s5 [3][3];
	logic signed [CB-1:0]      v_s6 [3][3];
	logic [2:0]                pos_s6, neg_s6;
	logic signed [CB-1:0]      cut_s6 [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			for (int k = 0; k <= DS; k++) vld_dv_s[k] <= 1'b0;
		end else if (adv) begin
			vld_s1      <= vertex_valid;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_dv_s[0] <= vld_s3;
			for (int k = 0; k < DS; k++) vld_dv_s[k+1] <= vld_dv_s[k];
			vld_s5      <= vld_dv_s[DS];
			vld_s6      <= vld_s5;
		end
	end

	// Distance: offset, products, then rounded and saturated sum.
	logic signed [CB-1:0] d_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d_c[i] = sat_sum((CB+2)'(rnd_sat(MW'(prod_s2[i][0])))
				+ (CB+2)'(rnd_sat(MW'(prod_s2[i][1])))
				+ (CB+2)'(rnd_sat(MW'(prod_s2[i][2]))));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					v_s1[i][k]    <= vin[i][k];
					diff_s1[i][k] <= (CB+1)'(vin[i][k]) - (CB+1)'(pp_q[k]);
					v_s2[i][k]    <= v_s1[i][k];
					prod_s2[i][k] <= diff_s1[i][k] * pn_q[k];
					v_s3[i][k]    <= v_s2[i][k];
				end
				d_s3[i] <= d_c[i];
			end
		end
	end

	// Classification and divider setup for each edge i -> i+1.
	logic signed [CB:0] thr_ext;
	logic signed [CB:0] d_ext [3];
	logic [CB-1:0]      mag_c [3];

	assign thr_ext = (CB+1)'(thr_q);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d_ext[i] = (CB+1)'(d_s3[i]);
			mag_c[i] = abs_c(d_s3[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				pos_dv_s[0][i] <= d_ext[i] > thr_ext;
				neg_dv_s[0][i] <= d_ext[i] < -thr_ext;
				rem_dv_s[0][i] <= (CB+2)'(mag_c[i]);
				den_dv_s[0][i] <= (CB+1)'(mag_c[i]) + (CB+1)'(mag_c[(i+1)%3]);
				t_dv_s[0][i]   <= '0;
				for (int k = 0; k < 3; k++) begin
					v_dv_s[0][i][k]   <= v_s3[i][k];
					dba_dv_s[0][i][k] <= (CB+1)'(v_s3[(i+1)%3][k]) - (CB+1)'(v_s3[i][k]);
				end
			end
		end
	end

	// Restoring divider, two quotient bits per stage.
	for (genvar g = 0; g < DS; g++) begin : g_div
		logic [CB+1:0] r_c [3];
		logic [FB-1:0] t_c [3];

		always_comb begin
			for (int e = 0; e < 3; e++) begin
				r_c[e] = rem_dv_s[g][e];
				t_c[e] = t_dv_s[g][e];
				for (int j = 0; j < 2; j++) begin
					if (2 * g + j < FB) begin
						r_c[e] = {r_c[e][CB:0], 1'b0};
						t_c[e] = {t_c[e][FB-2:0], 1'b0};
						if (r_c[e] >= (CB+2)'(den_dv_s[g][e])) begin
							r_c[e]    = r_c[e] - (CB+2)'(den_dv_s[g][e]);
							t_c[e][0] = 1'b1;
						end
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				pos_dv_s[g+1] <= pos_dv_s[g];
				neg_dv_s[g+1] <= neg_dv_s[g];
				for (int e = 0; e < 3; e++) begin
					rem_dv_s[g+1][e] <= r_c[e];
					den_dv_s[g+1][e] <= den_dv_s[g][e];
					t_dv_s[g+1][e]   <= t_c[e];
					for (int k = 0; k < 3; k++) begin
						v_dv_s[g+1][e][k]   <= v_dv_s[g][e][k];
						dba_dv_s[g+1][e][k] <= dba_dv_s[g][e][k];
					end
				end
			end
		end
	end

	// Cut points: a + (b - a) * t.
	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s5 <= pos_dv_s[DS];
			neg_s5 <= neg_dv_s[DS];
			pos_s6 <= pos_s5;
			neg_s6 <= neg_s5;
			for (int e = 0; e < 3; e++) begin
				for (int k = 0; k < 3; k++) begin
					v_s5[e][k]    <= v_dv_s[DS][e][k];
					prod_s5[e][k] <= dba_dv_s[DS][e][k] * $signed({1'b0, t_dv_s[DS][e]});
					v_s6[e][k]    <= v_s5[e][k];
					cut_s6[e][k]  <= sat_sum((CB+2)'(v_s5[e][k])
						+ (CB+2)'(rnd_sat(MW'(prod_s5[e][k]))));
				end
			end
		end
	end

	// Polygon assembly into up to three triangles.
	logic signed [CB-1:0] asm_tri [3][3][3];
	logic [2:0]           asm_side;
	logic [1:0]           asm_n;

	always_comb begin
		logic [2:0]           want;
		logic [2:0]           a3;
		logic [1:0]           start, a, b;
		logic [2:0]           cnt;
		logic signed [CB-1:0] poly [4][3];

		asm_n    = '0;
		asm_side = '0;
		want     = '0;
		a3       = '0;
		start    = '0;
		a        = '0;
		b        = '0;
		cnt      = '0;
		for (int q = 0; q < 4; q++) poly[q] = v_s6[0];
		for (int n = 0; n < 3; n++) begin
			for (int m = 0; m < 3; m++) asm_tri[n][m] = v_s6[m];
		end
		if (!(|pos_s6) || !(|neg_s6)) begin
			asm_n       = 2'd1;
			asm_side[0] = |neg_s6;
		end else begin
			for (int p = 0; p < 2; p++) begin
				want  = (p == 0) ? pos_s6 : neg_s6;
				start = want[0] ? 2'd0 : (want[1] ? 2'd1 : 2'd2);
				cnt   = '0;
				for (int k = 0; k < 3; k++) begin
					a3 = 3'(start) + 3'(k);
					if (a3 > 3'd2) a3 = a3 - 3'd3;
					a = a3[1:0];
					b = (a == 2'd2) ? 2'd0 : a + 2'd1;
					if (want[a] || (!pos_s6[a] && !neg_s6[a])) begin
						poly[cnt[1:0]] = v_s6[a];
						cnt            = cnt + 3'd1;
					end
					if ((pos_s6[a] && neg_s6[b]) || (neg_s6[a] && pos_s6[b])) begin
						poly[cnt[1:0]] = cut_s6[a];
						cnt            = cnt + 3'd1;
					end
				end
				if (cnt >= 3'd3) begin
					asm_tri[asm_n][0] = poly[0];
					asm_tri[asm_n][1] = poly[1];
					asm_tri[asm_n][2] = poly[2];
					asm_side[asm_n]   = p[0];
					asm_n             = asm_n + 2'd1;
				end
				if (cnt >= 3'd4) begin
					asm_tri[asm_n][0] = poly[0];
					asm_tri[asm_n][1] = poly[2];
					asm_tri[asm_n][2] = poly[3];
					asm_side[asm_n]   = p[0];
					asm_n             = asm_n + 2'd1;
				end
			end
		end
	end

	// Output register: holds one input's triangles and sends them in order.
	logic                 ser_vld_q;
	logic [1:0]           ser_idx_q, ser_cnt_q;
	logic [2:0]           ser_side_q;
	logic signed [CB-1:0] ser_tri_q [3][3][3];
	logic                 ser_last, ser_load_ok;

	assign ser_last     = ser_idx_q == ser_cnt_q - 2'd1;
	assign ser_load_ok  = !ser_vld_q || (tri_ready && ser_last);
	assign adv          = ser_load_ok || !vld_s6;
	assign vertex_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_vld_q <= 1'b0;
			ser_idx_q <= '0;
			ser_cnt_q <= '0;
		end else if (vld_s6 && ser_load_ok) begin
			ser_vld_q <= 1'b1;
			ser_idx_q <= '0;
			ser_cnt_q <= asm_n;
		end else if (ser_vld_q && tri_ready) begin
			if (ser_last) ser_vld_q <= 1'b0;
			else ser_idx_q <= ser_idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s6 && ser_load_ok) begin
			ser_tri_q  <= asm_tri;
			ser_side_q <= asm_side;
		end
	end

	assign tri_valid   = ser_vld_q;
	assign last_of_run = ser_last;
	assign side        = ser_side_q[ser_idx_q];
	assign out0_x      = ser_tri_q[ser_idx_q][0][0];
	assign out0_y      = ser_tri_q[ser_idx_q][0][1];
	assign out0_z      = ser_tri_q[ser_idx_q][0][2];
	assign out1_x      = ser_tri_q[ser_idx_q][1][0];
	assign out1_y      = ser_tri_q[ser_idx_q][1][1];
	assign out1_z      = ser_tri_q[ser_idx_q][1][2];
	assign out2_x      = ser_tri_q[ser_idx_q][2][0];
	assign out2_y      = ser_tri_q[ser_idx_q][2][1];
	assign out2_z      = ser_tri_q[ser_idx_q][2][2];

	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		ser_vld_q |-> (ser_cnt_q != 2'd0) && (ser_idx_q < ser_cnt_q))
		else $error("word index beyond triangle count");

	a_side_order: assert property (@(posedge clk) disable iff (!arst_n)
		tri_valid && tri_ready && !last_of_run |=> tri_valid && (side >= $past(side)))
		else $error("negative side word sent before positive side word");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 && !adv |=> vld_s6 && $stable(asm_n))
		else $error("last pipeline stage changed while stalled");

endmodule
